// ----- rtl/chunked_free_list_allocator_top_assert.svh -----
// Assertion macros used by the free-list allocator RTL.
`ifndef CHUNKED_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`define CHUNKED_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define CFLA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define CFLA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CFLA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cfla_pkg.sv -----
// Types and constants of the chunked free-list allocator.
`default_nettype none

package cfla_pkg;

  localparam int LINK_DEPTH = 256;
  localparam int IDX_W      = 8;
  localparam int LINK_W     = IDX_W + 1;
  localparam int CNT_W      = 9;
  localparam int CHUNK_W    = 5;

  // Request codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_GROW  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCHK,
    S_GPUSH,
    S_POP,
    S_RESP
  } state_t;

  // Link memory write port: bit 8 of data marks a valid next block.
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [LINK_W-1:0] data;
  } link_wr_t;

endpackage

`default_nettype wire

// ----- rtl/cfla_link_mem.sv -----
// Next-link memory of the free list: one write port, one registered read port.
`default_nettype none

module cfla_link_mem (
  input  wire                        clk,
  input  cfla_pkg::link_wr_t         wr,
  input  wire                        rd_en,
  input  wire  [cfla_pkg::IDX_W-1:0] rd_addr,
  output logic [cfla_pkg::LINK_W-1:0] rd_data
);
  import cfla_pkg::*;

  logic [LINK_W-1:0] mem [LINK_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/chunked_free_list_allocator_top.sv -----
// Free and allocate: the result goes to the output register from S_POP or S_RESP, held there
// while the output stalls; no new item is taken until that result is loaded.
// Grow of n chunks: for each chunk an S_GCHK step, then one link write per block in S_GPUSH.
// Allocate on an empty list first runs an implicit grow of one chunk.
// Synchronous reset empties the list and clears counters; link memory is not cleared.
`default_nettype none

module chunked_free_list_allocator_top #(
  parameter int BLOCKS_PER_CHUNK = 16,
  parameter int MAX_CHUNKS       = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  // config
  input  wire                          cfg_wr_en,
  input  wire  [cfla_pkg::CHUNK_W-1:0] cfg_wr_data,
  // request channel
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [1:0]                   opcode,
  input  wire  [cfla_pkg::IDX_W-1:0]   block_index,
  input  wire  [cfla_pkg::CHUNK_W-1:0] chunk_count,
  // result channel
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [1:0]                   status,
  output logic [cfla_pkg::IDX_W-1:0]   granted_block,
  output logic [cfla_pkg::CNT_W-1:0]   total_blocks,
  output logic [cfla_pkg::CNT_W-1:0]   free_blocks
);
  import cfla_pkg::*;

  `include "chunked_free_list_allocator_top_assert.svh"

  localparam int FIT_CHUNKS = LINK_DEPTH / BLOCKS_PER_CHUNK;
  localparam int CAP_FIX    = (MAX_CHUNKS < FIT_CHUNKS) ? MAX_CHUNKS : FIT_CHUNKS;
  localparam logic [CNT_W-1:0] CAP_FIX9 = CNT_W'(CAP_FIX);
  localparam logic [CNT_W-1:0] BPC9     = CNT_W'(BLOCKS_PER_CHUNK);
  localparam int OFS_W = (BLOCKS_PER_CHUNK > 1) ? $clog2(BLOCKS_PER_CHUNK) : 1;
  localparam logic [OFS_W-1:0] LAST_OFS = OFS_W'(BLOCKS_PER_CHUNK - 1);

  state_t state, state_next;

  logic [IDX_W-1:0]   head, head_next;
  logic               head_valid, head_valid_next;
  logic [CHUNK_W-1:0] chunks_used, chunks_used_next;
  logic [CNT_W-1:0]   blocks_total, blocks_total_next;
  logic [CNT_W-1:0]   free_count, free_count_next;
  logic [CHUNK_W-1:0] chunk_limit;
  logic [CHUNK_W-1:0] chunks_left, chunks_left_next;
  logic               is_alloc, is_alloc_next;
  logic [IDX_W-1:0]   base, base_next;
  logic [OFS_W-1:0]   ofs, ofs_next;
  logic [1:0]         res_status, res_status_next;
  logic [IDX_W-1:0]   res_grant, res_grant_next;

  logic               accept;
  logic               out_free;
  logic               out_load;
  logic [1:0]         fin_status;
  logic [IDX_W-1:0]   fin_grant;
  logic [CNT_W-1:0]   cap;
  logic               cap_hit;
  logic [IDX_W-1:0]   push_blk;

  link_wr_t           link_wr;
  logic               link_rd_en;
  logic [IDX_W-1:0]   link_rd_addr;
  logic [LINK_W-1:0]  link_rd_data;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Chunk limit in force
  assign cap      = (CNT_W'(chunk_limit) < CAP_FIX9) ? CNT_W'(chunk_limit) : CAP_FIX9;
  assign cap_hit  = (CNT_W'(chunks_used) >= cap);
  assign push_blk = base + IDX_W'(ofs);

  cfla_link_mem u_link_mem (
    .clk     (clk),
    .wr      (link_wr),
    .rd_en   (link_rd_en),
    .rd_addr (link_rd_addr),
    .rd_data (link_rd_data)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (opcode)
            OP_ALLOC: state_next = head_valid ? S_POP : S_GCHK;
            OP_GROW:  state_next = S_GCHK;
            default:  state_next = S_RESP;
          endcase
        end
      end
      S_GCHK: begin
        if (chunks_left == '0) begin
          state_next = is_alloc ? S_POP : S_RESP;
        end else if (cap_hit) begin
          state_next = S_RESP;
        end else begin
          state_next = S_GPUSH;
        end
      end
      S_GPUSH: begin
        if (ofs == LAST_OFS) begin
          state_next = S_GCHK;
        end
      end
      S_POP:   state_next = out_free ? S_IDLE : S_RESP;
      S_RESP:  state_next = out_free ? S_IDLE : S_RESP;
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    head_next         = head;
    head_valid_next   = head_valid;
    chunks_used_next  = chunks_used;
    blocks_total_next = blocks_total;
    free_count_next   = free_count;
    chunks_left_next  = chunks_left;
    is_alloc_next     = is_alloc;
    base_next         = base;
    ofs_next          = ofs;
    res_status_next   = res_status;
    res_grant_next    = res_grant;
    fin_status        = res_status;
    fin_grant         = res_grant;
    out_load          = 1'b0;
    link_wr           = '0;
    link_rd_en        = 1'b0;
    link_rd_addr      = head;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_status_next = ST_OK;
          res_grant_next  = '0;
          is_alloc_next   = 1'b0;
          unique case (opcode)
            OP_ALLOC: begin
              if (head_valid) begin
                link_rd_en = 1'b1;
              end else begin
                chunks_left_next = CHUNK_W'(1);
                is_alloc_next    = 1'b1;
              end
            end
            OP_FREE: begin
              if (CNT_W'(block_index) >= blocks_total) begin
                res_status_next = ST_BAD;
              end else begin
                link_wr.en      = 1'b1;
                link_wr.addr    = block_index;
                link_wr.data    = {head_valid, head};
                head_next       = block_index;
                head_valid_next = 1'b1;
                if (free_count < blocks_total) begin
                  free_count_next = free_count + CNT_W'(1);
                end
              end
            end
            OP_GROW: chunks_left_next = chunk_count;
            default: ;
          endcase
        end
      end
      S_GCHK: begin
        if (chunks_left == '0) begin
          link_rd_en = is_alloc;
        end else if (cap_hit) begin
          res_status_next = ST_OOM;
        end else begin
          chunks_used_next  = chunks_used + CHUNK_W'(1);
          blocks_total_next = blocks_total + BPC9;
          base_next         = blocks_total[IDX_W-1:0];
          ofs_next          = '0;
          chunks_left_next  = chunks_left - CHUNK_W'(1);
        end
      end
      S_GPUSH: begin
        // Push blocks of the new chunk in ascending order
        link_wr.en      = 1'b1;
        link_wr.addr    = push_blk;
        link_wr.data    = {head_valid, head};
        head_next       = push_blk;
        head_valid_next = 1'b1;
        if (free_count < blocks_total) begin
          free_count_next = free_count + CNT_W'(1);
        end
        ofs_next = ofs + OFS_W'(1);
      end
      S_POP: begin
        // Pop the head; link data read in the previous cycle
        head_next       = link_rd_data[IDX_W-1:0];
        head_valid_next = link_rd_data[LINK_W-1];
        if (free_count != '0) begin
          free_count_next = free_count - CNT_W'(1);
        end
        fin_status = ST_OK;
        fin_grant  = head;
        out_load   = out_free;
        if (!out_free) begin
          res_status_next = ST_OK;
          res_grant_next  = head;
        end
      end
      S_RESP:  out_load = out_free;
      default: ;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= '0;
      head_valid   <= 1'b0;
      chunks_used  <= '0;
      blocks_total <= '0;
      free_count   <= '0;
      chunk_limit  <= CHUNK_W'(16);
      chunks_left  <= '0;
      is_alloc     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      head         <= head_next;
      head_valid   <= head_valid_next;
      chunks_used  <= chunks_used_next;
      blocks_total <= blocks_total_next;
      free_count   <= free_count_next;
      chunks_left  <= chunks_left_next;
      is_alloc     <= is_alloc_next;
      if (cfg_wr_en) begin
        chunk_limit <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    base       <= base_next;
    ofs        <= ofs_next;
    res_status <= res_status_next;
    res_grant  <= res_grant_next;
    if (out_load) begin
      status        <= fin_status;
      granted_block <= fin_grant;
      total_blocks  <= blocks_total_next;
      free_blocks   <= free_count_next;
    end
  end

  `CFLA_ASSERT_ALWAYS(a_free_bounded, clk, rst, free_count <= blocks_total, "free count above pool size")
  `CFLA_ASSERT_ALWAYS(a_chunks_capped, clk, rst, CNT_W'(chunks_used) <= CAP_FIX9, "pool grew past its cap")
  `CFLA_ASSERT_IMPL(a_no_rw_overlap, clk, rst, link_wr.en && link_rd_en, link_wr.addr != link_rd_addr, "link read and write hit one entry")
  `CFLA_ASSERT_IMPL(a_push_in_pool, clk, rst, state == S_GPUSH, CNT_W'(push_blk) < blocks_total, "pushed block outside pool")
  `CFLA_ASSERT_NEXT(a_alloc_pops, clk, rst, accept && opcode == OP_ALLOC && head_valid, state == S_POP, "allocate on a non-empty list did not pop")

endmodule

`default_nettype wire

// ----- verif/chunked_free_list_allocator_top_tb.sv -----
// Self-checking testbench for the chunked free-list allocator: request driver, reply monitor.
`default_nettype none

module chunked_free_list_allocator_top_tb;
  import cfla_pkg::*;

  localparam int BLOCKS_PER_CHUNK = 16;
  localparam int MAX_CHUNKS       = 16;
  localparam logic [1:0] OP_NONE  = 2'd3;  // unused code, must be ignored

  typedef struct {
    logic [1:0]         op;
    logic [IDX_W-1:0]   blk;
    logic [CHUNK_W-1:0] cnt;
    bit                 reuse;  // free a block handed out earlier
  } request_t;

  typedef struct {
    logic [1:0]       st;
    logic [IDX_W-1:0] grant;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] nfree;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CHUNK_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = OP_ALLOC;
  logic [IDX_W-1:0] block_index = '0;
  logic [CHUNK_W-1:0] chunk_count = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [IDX_W-1:0] granted_block;
  logic [CNT_W-1:0] total_blocks;
  logic [CNT_W-1:0] free_blocks;

  chunked_free_list_allocator_top #(
    .BLOCKS_PER_CHUNK(BLOCKS_PER_CHUNK),
    .MAX_CHUNKS(MAX_CHUNKS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .block_index(block_index),
    .chunk_count(chunk_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .granted_block(granted_block),
    .total_blocks(total_blocks),
    .free_blocks(free_blocks)
  );

  always #5 clk = ~clk;

  request_t requests_todo[$];
  reply_t replies_due[$];
  logic [IDX_W-1:0] blocks_out[$];  // blocks granted and not yet given back
  int unsigned mismatches = 0;

  // Shadow free list
  logic [LINK_W-1:0] link_mem [LINK_DEPTH];
  logic [IDX_W-1:0] head_blk = '0;
  bit head_ok = 1'b0;
  int unsigned chunks_used = 0;
  int unsigned free_cnt = 0;
  int unsigned limit_reg = 16;

  task automatic flag_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int unsigned pool_cap();
    int unsigned c;
    c = limit_reg;
    if (c > MAX_CHUNKS) c = MAX_CHUNKS;
    if (c > LINK_DEPTH / BLOCKS_PER_CHUNK) c = LINK_DEPTH / BLOCKS_PER_CHUNK;
    return c;
  endfunction

  function automatic void push_free(logic [IDX_W-1:0] b);
    link_mem[b] = {head_ok, head_blk};
    head_blk = b;
    head_ok = 1'b1;
    if (free_cnt < chunks_used * BLOCKS_PER_CHUNK) free_cnt++;
  endfunction

  function automatic bit grow_chunk();
    int unsigned base;
    if (chunks_used >= pool_cap()) return 1'b0;
    base = chunks_used * BLOCKS_PER_CHUNK;
    chunks_used++;
    for (int i = 0; i < BLOCKS_PER_CHUNK; i++) push_free(IDX_W'(base + i));
    return 1'b1;
  endfunction

  // Apply one request to the shadow list and return the reply it should produce
  function automatic reply_t serve_request(request_t r);
    reply_t y;
    logic [LINK_W-1:0] nxt_link;
    y.st = ST_OK;
    y.grant = '0;
    case (r.op)
      OP_ALLOC: begin
        // empty list grows by one chunk first
        if (!head_ok) void'(grow_chunk());
        if (!head_ok) begin
          y.st = ST_OOM;
        end else begin
          nxt_link = link_mem[head_blk];
          y.grant = head_blk;
          head_blk = nxt_link[IDX_W-1:0];
          head_ok = nxt_link[IDX_W];
          if (free_cnt > 0) free_cnt--;
        end
      end
      OP_FREE: begin
        if (r.blk >= chunks_used * BLOCKS_PER_CHUNK) y.st = ST_BAD;
        else push_free(r.blk);
      end
      OP_GROW: begin
        for (int i = 0; i < r.cnt; i++) begin
          if (!grow_chunk()) begin
            y.st = ST_OOM;
            break;
          end
        end
      end
      default: ;
    endcase
    y.total = CNT_W'(chunks_used * BLOCKS_PER_CHUNK);
    y.nfree = CNT_W'(free_cnt);
    return y;
  endfunction

  // Request driver: bursts of items with random gaps
  request_t cur_req;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    request_t nxt;
    reply_t pred;
    bit send;
    int unsigned pick;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      send = in_valid && in_stall;
      if (in_valid && !in_stall) begin
        pred = serve_request(cur_req);
        replies_due.push_back(pred);
        if (cur_req.op == OP_ALLOC && pred.st == ST_OK) blocks_out.push_back(pred.grant);
      end
      if (!send) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (requests_todo.size() != 0) begin
          nxt = requests_todo.pop_front();
          if (nxt.reuse && blocks_out.size() != 0) begin
            pick = $urandom_range(0, blocks_out.size() - 1);
            nxt.blk = blocks_out[pick];
            blocks_out.delete(pick);
          end
          cur_req = nxt;
          opcode <= nxt.op;
          block_index <= nxt.blk;
          chunk_count <= nxt.cnt;
          send = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
      in_valid <= send;
    end
  end

  // Reply monitor and stall pattern
  int unsigned stall_mode = 0;
  int unsigned stall_run = 0;
  int unsigned stall_cyc = 0;

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          flag_mismatch("reply with no item outstanding");
        end else begin
          want = replies_due.pop_front();
          if (status !== want.st)
            flag_mismatch($sformatf("status got %0d want %0d", status, want.st));
          if (granted_block !== want.grant)
            flag_mismatch($sformatf("granted_block got %0d want %0d", granted_block, want.grant));
          if (total_blocks !== want.total)
            flag_mismatch($sformatf("total_blocks got %0d want %0d", total_blocks, want.total));
          if (free_blocks !== want.nfree)
            flag_mismatch($sformatf("free_blocks got %0d want %0d", free_blocks, want.nfree));
        end
      end
      if (stall_run == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_run = $urandom_range(20, 150);
      end
      stall_run--;
      stall_cyc++;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= 1'($urandom_range(0, 1));
        2: out_stall <= ($urandom_range(0, 7) != 0);
        default: out_stall <= (stall_cyc % 8 < 3);
      endcase
    end
  end

  task automatic queue_req(logic [1:0] op, int unsigned blk, int unsigned cnt, bit reuse);
    request_t r;
    r.op = op;
    r.blk = IDX_W'(blk);
    r.cnt = CHUNK_W'(cnt);
    r.reuse = reuse;
    requests_todo.push_back(r);
  endtask

  // Mostly alloc / free-back traffic, with stray frees, grows and unused codes
  task automatic queue_random(int unsigned n);
    int unsigned roll;
    int unsigned cnt;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        queue_req(OP_ALLOC, $urandom_range(0, 255), $urandom_range(0, 31), 1'b0);
      end else if (roll < 76) begin
        queue_req(OP_FREE, $urandom_range(0, 255), $urandom_range(0, 31), 1'b1);
      end else if (roll < 86) begin
        queue_req(OP_FREE, $urandom_range(0, 255), $urandom_range(0, 31), 1'b0);
      end else if (roll < 96) begin
        cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
        queue_req(OP_GROW, $urandom_range(0, 255), cnt, 1'b0);
      end else begin
        queue_req(OP_NONE, $urandom_range(0, 255), $urandom_range(0, 31), 1'b0);
      end
    end
  endtask

  // Waits until every queued request is sent and every reply is back
  task automatic drain_replies();
    @(negedge clk);
    while (requests_todo.size() != 0 || in_valid || replies_due.size() != 0) @(negedge clk);
  endtask

  task automatic set_limit(int unsigned v);
    drain_replies();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= CHUNK_W'(v);
    limit_reg = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Stimulus sequence
  initial begin
    int unsigned steps[8];
    steps = '{2, 3, $urandom_range(4, 15), 16, 5, 31, 0, 16};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // no chunks allowed at all
    set_limit(0);
    queue_req(OP_ALLOC, 0, 0, 1'b0);
    queue_req(OP_GROW, 0, 0, 1'b0);
    queue_req(OP_GROW, 0, 16, 1'b0);
    queue_req(OP_GROW, 255, 31, 1'b0);
    queue_req(OP_FREE, 0, 0, 1'b0);
    queue_req(OP_FREE, 255, 0, 1'b0);
    queue_req(OP_NONE, 255, 31, 1'b0);

    // single chunk: implicit grow, double free, edge of region, capped grow
    set_limit(1);
    queue_req(OP_ALLOC, 0, 0, 1'b0);
    queue_req(OP_ALLOC, 0, 0, 1'b0);
    queue_req(OP_FREE, 15, 0, 1'b0);
    queue_req(OP_FREE, 15, 0, 1'b0);
    queue_req(OP_FREE, 16, 0, 1'b0);
    queue_req(OP_GROW, 0, 1, 1'b0);
    queue_req(OP_GROW, 0, 0, 1'b0);
    queue_req(OP_ALLOC, 0, 0, 1'b0);
    queue_req(OP_ALLOC, 0, 0, 1'b0);
    queue_req(OP_NONE, 0, 0, 1'b0);
    queue_random(100);

    foreach (steps[i]) begin
      set_limit(steps[i]);
      queue_random(100);
    end

    drain_replies();
    repeat (20) @(posedge clk);
    if (replies_due.size() != 0) flag_mismatch("replies still outstanding at end");
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/cfla_pkg.sv
rtl/cfla_link_mem.sv
rtl/chunked_free_list_allocator_top.sv
verif/chunked_free_list_allocator_top_tb.sv
